/* rtl/fspa_pkg.sv */
// ---------------------------------------------------------------------------
// fspa_pkg
// Shared types and codes for the fit-strategy partition allocator.
// ---------------------------------------------------------------------------
package fspa_pkg;

  // fixed widths of the item fields
  localparam int INDEX_W = 7;
  localparam int AMT_W   = 16;
  localparam int PID_W   = 16;
  localparam int STRAT_W = 2;
  localparam int OP_W    = 2;

  // command codes produced by the front end
  localparam logic [OP_W-1:0] OP_SET   = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FAIL  = 2'd2;

  // search strategies
  localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
  localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
  localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

  // classified command passed from front to back
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [STRAT_W-1:0] strat;
    logic [INDEX_W-1:0] index;
    logic [AMT_W-1:0]   amount;
    logic [PID_W-1:0]   pid;
  } cmd_t;

endpackage

/* rtl/fspa_ram.sv */
// ---------------------------------------------------------------------------
// fspa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module fspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/fspa_front.sv */
// ---------------------------------------------------------------------------
// fspa_front
// Accepts items, decodes them into commands and holds them in a
// two-entry queue for the back end.
// ---------------------------------------------------------------------------
module fspa_front
  import fspa_pkg::*;
#(
  parameter int BLOCKS = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               kind,
  input  logic [STRAT_W-1:0] strategy,
  input  logic [INDEX_W-1:0] block_index,
  input  logic [AMT_W-1:0]   amount,
  input  logic [PID_W-1:0]   process_id,
  input  logic               init_busy,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  logic               cmd_pop
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       dec;
  logic       take;

  // classify the incoming item
  always_comb begin
    dec.strat  = strategy;
    dec.index  = block_index;
    dec.amount = amount;
    dec.pid    = process_id;
    if (!kind) begin
      dec.op = (32'(block_index) < BLOCKS) ? OP_SET : OP_FAIL;
    end else begin
      dec.op = (strategy <= STRAT_WORST) ? OP_ALLOC : OP_FAIL;
    end
  end

  // no transfers while the back end clears its table
  assign full      = (count == 2'd2) || init_busy;
  assign take      = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (take) begin
      q[wr_ptr] <= dec;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (take) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (take && !cmd_pop) begin
        count <= count + 2'd1;
      end else if (!take && cmd_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* rtl/fspa_back.sv */
// ---------------------------------------------------------------------------
// fspa_back
// Executes commands against the partition table: clearing pass after
// reset, size writes, failed results for rejected items, and a one-entry-per-cycle search for allocations.
// ---------------------------------------------------------------------------
module fspa_back
  import fspa_pkg::*;
#(
  parameter int BLOCKS    = 128,
  parameter int SIZE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               init_busy,
  input  logic               pop,
  output logic               empty,
  output logic               success,
  output logic [INDEX_W-1:0] chosen_index
);

  localparam int              IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(BLOCKS - 1);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state;
  logic [IDX_W-1:0]     init_addr;
  logic [IDX_W-1:0]     scan_addr;
  logic                 scan_issue;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_idx;
  logic [SIZE_BITS-1:0] need;
  logic [STRAT_W-1:0]   strat;
  logic [PID_W-1:0]     pid;
  logic                 have;
  logic [IDX_W-1:0]     best_idx;
  logic [SIZE_BITS-1:0] best_size;
  logic                 res_valid;
  logic                 res_success;
  logic [INDEX_W-1:0]   res_index;

  logic                 slot_free;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS:0]   wr_data;
  logic                 own_wr;
  logic [SIZE_BITS:0]   rd_data;
  logic                 ent_alloc;
  logic [SIZE_BITS-1:0] ent_size;
  logic                 qualify;
  logic                 better;
  logic                 take;
  logic                 res_load;
  logic                 load_ok;
  logic [INDEX_W-1:0]   load_idx;

  // size table: {allocated flag, size}
  fspa_ram #(
    .WIDTH (SIZE_BITS + 1),
    .DEPTH (BLOCKS)
  ) u_size_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (scan_issue),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  // owner table, written on each successful allocation
  fspa_ram #(
    .WIDTH (PID_W),
    .DEPTH (BLOCKS)
  ) u_owner_ram (
    .clk     (clk),
    .wr_en   (own_wr),
    .wr_addr (best_idx),
    .wr_data (pid),
    .rd_en   (1'b0),
    .rd_addr ('0),
    .rd_data ()
  );

  assign init_busy    = (state == S_INIT);
  assign slot_free    = !res_valid || pop;
  assign empty        = !res_valid;
  assign success      = res_success;
  assign chosen_index = res_index;

  // compare the entry read back against the current pick
  assign ent_alloc = rd_data[SIZE_BITS];
  assign ent_size  = rd_data[SIZE_BITS-1:0];
  assign qualify   = rd_valid && !ent_alloc && (ent_size >= need);
  assign better    = ((strat == STRAT_BEST) && (ent_size < best_size)) ||
                     ((strat == STRAT_WORST) && (ent_size > best_size));
  assign take      = qualify && (!have || better);

  // table writes, command pops and result loads
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = init_addr;
    wr_data  = '0;
    own_wr   = 1'b0;
    cmd_pop  = 1'b0;
    res_load = 1'b0;
    load_ok  = 1'b0;
    load_idx = '0;
    case (state)
      S_INIT: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_SET: begin
              if (slot_free) begin
                wr_en    = 1'b1;
                wr_addr  = IDX_W'(cmd.index);
                wr_data  = {1'b0, SIZE_BITS'(cmd.amount)};
                cmd_pop  = 1'b1;
                res_load = 1'b1;
                load_ok  = 1'b1;
                load_idx = cmd.index;
              end
            end
            OP_ALLOC: begin
              cmd_pop = 1'b1;
            end
            default: begin
              if (slot_free) begin
                cmd_pop  = 1'b1;
                res_load = 1'b1;
              end
            end
          endcase
        end
      end
      S_DONE: begin
        if (slot_free) begin
          res_load = 1'b1;
          if (have) begin
            wr_en    = 1'b1;
            wr_addr  = best_idx;
            wr_data  = {1'b1, best_size};
            own_wr   = 1'b1;
            load_ok  = 1'b1;
            load_idx = INDEX_W'(best_idx);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer and result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_addr  <= '0;
      scan_issue <= 1'b0;
      rd_valid   <= 1'b0;
      have       <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          init_addr <= init_addr + 1'b1;
          if (init_addr == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_pop && (cmd.op == OP_ALLOC)) begin
            have       <= 1'b0;
            scan_issue <= 1'b1;
            rd_valid   <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_valid <= scan_issue;
          if (scan_issue && (scan_addr == LAST)) begin
            scan_issue <= 1'b0;
          end
          if (take) begin
            have <= 1'b1;
          end
          if (rd_valid && (rd_idx == LAST)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // search datapath and result payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_success <= load_ok;
      res_index   <= load_idx;
    end
    if ((state == S_IDLE) && cmd_pop && (cmd.op == OP_ALLOC)) begin
      need      <= SIZE_BITS'(cmd.amount);
      strat     <= cmd.strat;
      pid       <= cmd.pid;
      scan_addr <= '0;
    end else if ((state == S_SCAN) && scan_issue) begin
      scan_addr <= scan_addr + 1'b1;
    end
    if (state == S_SCAN) begin
      rd_idx <= scan_addr;
      if (take) begin
        best_idx  <= rd_idx;
        best_size <= ent_size;
      end
    end
  end

endmodule

/* rtl/fit_strategy_partition_allocator_core.sv */
// ---------------------------------------------------------------------------
// fit_strategy_partition_allocator_core
// Fixed-partition allocator with first-, best- and worst-fit search.
// ---------------------------------------------------------------------------
// results: a set or rejected item passes through the command queue and then
//   the result register; an allocation first walks the whole size table
// search: allocations run one at a time, limited by the single read
//   port of the size table, which the search walks one entry per cycle
// reset: synchronous; afterwards every entry of the size table is cleared,
//   with full held high, before the first item is taken
module fit_strategy_partition_allocator_core
  import fspa_pkg::*;
#(
  parameter int BLOCKS    = 128,
  parameter int SIZE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               kind,
  input  logic [STRAT_W-1:0] strategy,
  input  logic [INDEX_W-1:0] block_index,
  input  logic [AMT_W-1:0]   amount,
  input  logic [PID_W-1:0]   process_id,
  output logic               empty,
  input  logic               pop,
  output logic               success,
  output logic [INDEX_W-1:0] chosen_index
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic init_busy;

  // decode and command queue
  fspa_front #(
    .BLOCKS (BLOCKS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .strategy    (strategy),
    .block_index (block_index),
    .amount      (amount),
    .process_id  (process_id),
    .init_busy   (init_busy),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  // table engine and result register
  fspa_back #(
    .BLOCKS    (BLOCKS),
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .init_busy    (init_busy),
    .pop          (pop),
    .empty        (empty),
    .success      (success),
    .chosen_index (chosen_index)
  );

endmodule

/* rtl/fspa_checker.sv */
// ---------------------------------------------------------------------------
// fspa_checker
// Port-level checks for the partition allocator, bound to the top level.
// ---------------------------------------------------------------------------
module fspa_checker
  import fspa_pkg::*;
#(
  parameter int BLOCKS = 128
) (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               pop,
  input logic               empty,
  input logic               success,
  input logic [INDEX_W-1:0] chosen_index
);

  // no result and no transfer right after reset (clearing pass)
  a_reset_state: assert property (@(posedge clk)
    rst |=> (empty && full))
    else $error("result or input open right after reset");

  // a waiting result holds until it is taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(success) && $stable(chosen_index)))
    else $error("waiting result changed");

  // a failed result reports index zero
  a_fail_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && !success) |-> (chosen_index == '0))
    else $error("failed result with nonzero index");

  // a successful result names an existing partition
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && success) |-> (32'(chosen_index) < BLOCKS))
    else $error("result index beyond the table");

endmodule

bind fit_strategy_partition_allocator_core fspa_checker #(
  .BLOCKS (BLOCKS)
) u_fspa_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .pop          (pop),
  .empty        (empty),
  .success      (success),
  .chosen_index (chosen_index)
);

/* sim/fit_strategy_partition_allocator_core_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fit_strategy_partition_allocator_core_tb
// Self-checking bench for the partition allocator. A short directed table
// covers empty-table requests, extremes, ties and the unused strategy code.
// Then come about 1500 random set and request items. Every result transfer
// is compared with its directed row or a behavioral copy of the partition
// tables, with random sender bursts and receiver stalls throughout.
// ---------------------------------------------------------------------------
module fit_strategy_partition_allocator_core_tb;
  import fspa_pkg::*;

  localparam int NUM_PARTS    = 128;
  localparam int RANDOM_ITEMS = 1525;
  localparam int DRAIN_CYCLES = NUM_PARTS + 12;

  // item kinds and the strategy code the block leaves unused
  localparam logic               KIND_SET     = 1'b0;
  localparam logic               KIND_ALLOC   = 1'b1;
  localparam logic [STRAT_W-1:0] STRAT_UNUSED = 2'd3;

  typedef struct packed {
    logic               kind;
    logic [STRAT_W-1:0] strat;
    logic [INDEX_W-1:0] index;
    logic [AMT_W-1:0]   amount;
    logic [PID_W-1:0]   pid;
  } part_req_t;

  typedef struct packed {
    logic               ok;
    logic [INDEX_W-1:0] where;
  } part_grant_t;

  typedef struct packed {
    part_req_t   req;
    logic        fixed;
    part_grant_t want;
  } dir_row_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               push         = 1'b0;
  logic               kind         = 1'b0;
  logic [STRAT_W-1:0] strategy     = '0;
  logic [INDEX_W-1:0] block_index  = '0;
  logic [AMT_W-1:0]   amount       = '0;
  logic [PID_W-1:0]   process_id   = '0;
  logic               pop          = 1'b0;
  logic               full;
  logic               empty;
  logic               success;
  logic [INDEX_W-1:0] chosen_index;

  // shadow copy of the partition tables
  logic [AMT_W-1:0] part_size  [NUM_PARTS];
  logic [PID_W-1:0] part_owner [NUM_PARTS];
  logic             part_busy  [NUM_PARTS];

  part_grant_t pending_grants[$];
  dir_row_t    dir_rows [25];
  int          mismatches  = 0;
  int          n_sets      = 0;
  int          n_granted   = 0;
  int          n_refused   = 0;
  int          burst_left  = 0;

  fit_strategy_partition_allocator_core #(
    .BLOCKS    (NUM_PARTS),
    .SIZE_BITS (AMT_W)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .strategy     (strategy),
    .block_index  (block_index),
    .amount       (amount),
    .process_id   (process_id),
    .empty        (empty),
    .pop          (pop),
    .success      (success),
    .chosen_index (chosen_index)
  );

  always #4 clk = ~clk;

  // apply one item to the shadow tables and return its grant
  function automatic part_grant_t grant_partition(input part_req_t r);
    part_grant_t      g;
    int               pick;
    logic [AMT_W-1:0] left;
    logic [AMT_W-1:0] best_left;
    g         = '0;
    pick      = -1;
    best_left = '0;
    if (r.kind == KIND_SET) begin
      if (int'(r.index) < NUM_PARTS) begin
        part_size[r.index] = r.amount;
        part_busy[r.index] = 1'b0;
        g.ok               = 1'b1;
        g.where            = r.index;
      end
    end else if (r.strat != STRAT_UNUSED) begin
      for (int i = 0; i < NUM_PARTS; i++) begin
        if (!part_busy[i] && part_size[i] >= r.amount) begin
          left = part_size[i] - r.amount;
          // first fit keeps its first hit; ties keep the lower index
          if (pick < 0 || (r.strat == STRAT_BEST && left < best_left) ||
              (r.strat == STRAT_WORST && left > best_left)) begin
            pick      = i;
            best_left = left;
          end
        end
      end
      if (pick >= 0) begin
        part_owner[pick] = r.pid;
        part_busy[pick]  = 1'b1;
        g.ok             = 1'b1;
        g.where          = pick[INDEX_W-1:0];
      end
    end
    return g;
  endfunction

  // sizes: mostly small so requests hit, fits tie and tables fill up
  function automatic logic [AMT_W-1:0] pick_amount();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5)  return '0;
    if (sel < 10) return '1;
    if (sel < 35) return AMT_W'($urandom);
    return AMT_W'($urandom_range(0, 300));
  endfunction

  // sender pacing: bursts of random length separated by idle gaps
  task automatic pace_sender();
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // drive one item, wait for its transfer, and log what it should return
  task automatic send_request(input part_req_t r, input logic fixed,
                              input part_grant_t want);
    part_grant_t g;
    push        <= 1'b1;
    kind        <= r.kind;
    strategy    <= r.strat;
    block_index <= r.index;
    amount      <= r.amount;
    process_id  <= r.pid;
    @(posedge clk);
    while (full) @(posedge clk);
    g = grant_partition(r);
    pending_grants.push_back(fixed ? want : g);
    if (r.kind == KIND_SET) n_sets++;
    else if (g.ok)          n_granted++;
    else                    n_refused++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  // receiver: stretches of always-pop, random pop and long stalls
  int pop_mode    = 0;
  int pop_stretch = 0;
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop_stretch == 0) begin
        pop_mode    = $urandom_range(0, 2);
        pop_stretch = $urandom_range(5, 60);
      end
      pop_stretch--;
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= $urandom_range(0, 1);
        default: pop <= 1'b0;
      endcase
    end
  end

  // compare each result transfer with the oldest pending grant
  always @(posedge clk) begin : result_check
    part_grant_t exp_g;
    if (!rst && pop && !empty) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected result: success=%0d chosen_index=%0d", success, chosen_index);
        mismatches++;
      end else begin
        exp_g = pending_grants.pop_front();
        if (success !== exp_g.ok) begin
          $error("success: expected %0d, got %0d", exp_g.ok, success);
          mismatches++;
        end
        if (chosen_index !== exp_g.where) begin
          $error("chosen_index: expected %0d, got %0d", exp_g.where, chosen_index);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    part_req_t r;
    int        sel;
    for (int i = 0; i < NUM_PARTS; i++) begin
      part_size[i]  = '0;
      part_owner[i] = '0;
      part_busy[i]  = 1'b0;
    end

    // directed table: request, typed expectation flag, expected grant
    dir_rows = '{
      // empty table: zero-size requests succeed, ties go low
      '{'{KIND_ALLOC, STRAT_FIRST,  7'd0,   16'h0000, 16'h0001}, 1'b1, '{1'b1, 7'd0}},
      '{'{KIND_ALLOC, STRAT_BEST,   7'd0,   16'h0000, 16'hFFFF}, 1'b1, '{1'b1, 7'd1}},
      '{'{KIND_ALLOC, STRAT_WORST,  7'd127, 16'h0000, 16'h0000}, 1'b1, '{1'b1, 7'd2}},
      '{'{KIND_ALLOC, STRAT_FIRST,  7'd0,   16'h0001, 16'h1234}, 1'b1, '{1'b0, 7'd0}},
      '{'{KIND_ALLOC, STRAT_UNUSED, 7'd0,   16'h0000, 16'h4321}, 1'b1, '{1'b0, 7'd0}},
      // size setup, top index and full-scale size
      '{'{KIND_SET,   STRAT_FIRST,  7'd127, 16'hFFFF, 16'h0000}, 1'b1, '{1'b1, 7'd127}},
      '{'{KIND_SET,   STRAT_WORST,  7'd0,   16'h0000, 16'hFFFF}, 1'b1, '{1'b1, 7'd0}},
      '{'{KIND_SET,   STRAT_FIRST,  7'd5,   16'd100,  16'h0000}, 1'b1, '{1'b1, 7'd5}},
      '{'{KIND_SET,   STRAT_BEST,   7'd6,   16'd200,  16'h0000}, 1'b1, '{1'b1, 7'd6}},
      '{'{KIND_SET,   STRAT_FIRST,  7'd7,   16'd100,  16'h0000}, 1'b1, '{1'b1, 7'd7}},
      // strategy choice and tie break
      '{'{KIND_ALLOC, STRAT_WORST,  7'd0,   16'd50,   16'hA5A5}, 1'b1, '{1'b1, 7'd127}},
      '{'{KIND_ALLOC, STRAT_BEST,   7'd0,   16'd100,  16'h5A5A}, 1'b1, '{1'b1, 7'd5}},
      '{'{KIND_ALLOC, STRAT_FIRST,  7'd0,   16'd100,  16'h0F0F}, 1'b1, '{1'b1, 7'd6}},
      '{'{KIND_ALLOC, STRAT_BEST,   7'd0,   16'd100,  16'hF0F0}, 1'b1, '{1'b1, 7'd7}},
      // nothing left that fits
      '{'{KIND_ALLOC, STRAT_FIRST,  7'd0,   16'h0001, 16'h0002}, 1'b1, '{1'b0, 7'd0}},
      '{'{KIND_ALLOC, STRAT_FIRST,  7'd0,   16'hFFFF, 16'h0003}, 1'b1, '{1'b0, 7'd0}},
      // set frees an allocated partition
      '{'{KIND_SET,   STRAT_FIRST,  7'd127, 16'hFFFF, 16'h0000}, 1'b1, '{1'b1, 7'd127}},
      '{'{KIND_ALLOC, STRAT_BEST,   7'd0,   16'hFFFF, 16'hFFFF}, 1'b1, '{1'b1, 7'd127}},
      '{'{KIND_SET,   STRAT_FIRST,  7'd64,  16'h5555, 16'h0000}, 1'b1, '{1'b1, 7'd64}},
      '{'{KIND_SET,   STRAT_FIRST,  7'd63,  16'hAAAA, 16'h0000}, 1'b1, '{1'b1, 7'd63}},
      '{'{KIND_ALLOC, STRAT_WORST,  7'd0,   16'h5555, 16'h00FF}, 1'b1, '{1'b1, 7'd63}},
      '{'{KIND_ALLOC, STRAT_FIRST,  7'd0,   16'h0000, 16'hFF00}, 1'b1, '{1'b1, 7'd0}},
      // rest left to the shadow tables
      '{'{KIND_ALLOC, STRAT_BEST,   7'd0,   16'h0000, 16'h1111}, 1'b0, '{1'b0, 7'd0}},
      '{'{KIND_ALLOC, STRAT_WORST,  7'd0,   16'h0000, 16'h2222}, 1'b0, '{1'b0, 7'd0}},
      '{'{KIND_SET,   STRAT_UNUSED, 7'd42,  16'h8000, 16'h3333}, 1'b0, '{1'b0, 7'd0}}
    };

    // hold reset, then release it on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      pace_sender();
      send_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].want);
    end

    // hold off until the directed results are all back
    push <= 1'b0;
    drain_results();
    @(negedge clk);

    // random traffic: mostly sets and valid requests, a few unused codes
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel     = $urandom_range(0, 99);
      r.kind  = (sel < 35) ? KIND_SET : KIND_ALLOC;
      r.strat = (sel >= 95) ? STRAT_UNUSED : STRAT_W'($urandom_range(0, 2));
      if (r.kind == KIND_SET && $urandom_range(0, 9) == 0)
        r.strat = STRAT_UNUSED;
      r.index  = INDEX_W'($urandom_range(0, NUM_PARTS - 1));
      r.amount = pick_amount();
      r.pid    = PID_W'($urandom);
      pace_sender();
      send_request(r, 1'b0, '0);
    end
    push <= 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d sets, %0d granted and %0d refused requests",
             n_sets, n_granted, n_refused);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
